FILE: hdl/counting_semaphore_lifo_waiters_defines.svh
// -----------------------------------------------------------------------------
// Assertion macros for the counting semaphore block
// Concurrent checks, compiled out for synthesis.
// -----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_LIFO_WAITERS_DEFINES_SVH
`define COUNTING_SEMAPHORE_LIFO_WAITERS_DEFINES_SVH

`ifndef SYNTHESIS
`define CSL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csl assertion failed");
`define CSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csl assertion failed");
`else
`define CSL_ASSERT_SAME(label, clk, rst, ante, cons)
`define CSL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/csl_pkg.sv
// -----------------------------------------------------------------------------
// csl_pkg
// Types and constants shared by the semaphore and its waiter stack.
// -----------------------------------------------------------------------------
package csl_pkg;

  localparam int NUM_TASKS   = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int TASK_W      = 3;
  localparam int DEPTH_W     = $clog2(NUM_TASKS + 1);
  localparam int OUT_CNT_W   = 16;
  localparam int CFG_W       = 16;

  localparam logic REQ_WAIT = 1'b0;
  localparam logic REQ_POST = 1'b1;

  localparam logic [1:0] ST_GRANTED = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_WOKE    = 2'd2;
  localparam logic [1:0] ST_BANKED  = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [TASK_W-1:0] task_id;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [TASK_W-1:0]    woken_task;
    logic                 overflow_flag;
    logic [OUT_CNT_W-1:0] count_now;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_ctl_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [DEPTH_W-1:0] depth;
  } stack_stat_t;

endpackage

FILE: hdl/csl_cell.sv
// -----------------------------------------------------------------------------
// csl_cell
// One waiter stack entry; takes its upper neighbor on push, lower on pop.
// -----------------------------------------------------------------------------
module csl_cell
  import csl_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [TASK_W-1:0] from_prev,
  input  logic [TASK_W-1:0] from_next,
  output logic [TASK_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q <= from_prev;
    end else if (ctl.pop) begin
      q <= from_next;
    end
  end

endmodule

FILE: hdl/csl_stack.sv
// -----------------------------------------------------------------------------
// csl_stack
// LIFO of waiting tasks as a row of shifting cells; cell 0 is the top.
// -----------------------------------------------------------------------------
`include "counting_semaphore_lifo_waiters_defines.svh"

module csl_stack
  import csl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  stack_ctl_t        ctl,
  input  logic [TASK_W-1:0] push_data,
  output logic [TASK_W-1:0] top,
  output stack_stat_t       stat
);

  logic [TASK_W-1:0]  q [NUM_TASKS];
  logic [TASK_W-1:0]  prev_d [NUM_TASKS];
  logic [TASK_W-1:0]  next_d [NUM_TASKS];
  logic [DEPTH_W-1:0] depth;
  cell_ctl_t          cctl;

  assign cctl.push = ctl.push;
  assign cctl.pop  = ctl.pop;

  genvar i;
  generate
    for (i = 0; i < NUM_TASKS; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign prev_d[i] = push_data;
      end else begin : g_mid
        assign prev_d[i] = q[i-1];
      end
      if (i == NUM_TASKS - 1) begin : g_last
        assign next_d[i] = '0;
      end else begin : g_inner
        assign next_d[i] = q[i+1];
      end
      csl_cell u_cell (
        .clk       (clk),
        .ctl       (cctl),
        .from_prev (prev_d[i]),
        .from_next (next_d[i]),
        .q         (q[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      depth <= '0;
    end else if (ctl.push) begin
      depth <= depth + 1'b1;
    end else if (ctl.pop) begin
      depth <= depth - 1'b1;
    end
  end

  assign top        = q[0];
  assign stat.depth = depth;
  assign stat.full  = (depth == DEPTH_W'(NUM_TASKS));
  assign stat.empty = (depth == '0);

  `CSL_ASSERT_SAME(a_depth_range, clk, rst, 1'b1, depth <= DEPTH_W'(NUM_TASKS))
  `CSL_ASSERT_SAME(a_push_pop_excl, clk, rst, 1'b1, !(ctl.push && ctl.pop))
  `CSL_ASSERT_NEXT(a_push_grows, clk, rst, ctl.push && !ctl.clear,
                   depth == $past(depth) + 1'b1)
  `CSL_ASSERT_NEXT(a_pop_shrinks, clk, rst, ctl.pop && !ctl.clear,
                   depth == $past(depth) - 1'b1)

endmodule

FILE: hdl/counting_semaphore_lifo_waiters.sv
// -----------------------------------------------------------------------------
// counting_semaphore_lifo_waiters
// Results are registered: result and done are loaded when a request is taken.
// Throughput: one request per cycle; busy stays low, the count register and
// the stack pointer both settle in the same cycle.
// Reset (rst, synchronous): count zero, no waiters, no result pending.
// The receiver cannot stall; done marks each result for one cycle.
// -----------------------------------------------------------------------------
`include "counting_semaphore_lifo_waiters_defines.svh"

module counting_semaphore_lifo_waiters
  import csl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             done,
  output res_t             result
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [COUNT_WIDTH-1:0]           count;
  logic [COUNT_WIDTH-1:0]           count_next;
  logic [COUNT_WIDTH+CFG_W-1:0]     cfg_ext;
  logic [COUNT_WIDTH+OUT_CNT_W-1:0] cnt_ext;
  logic                             accept;
  logic                             cfg_wr;
  stack_ctl_t                       sctl;
  stack_stat_t                      sstat;
  logic [TASK_W-1:0]                top;
  res_t                             res_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_ext   = {{COUNT_WIDTH{1'b0}}, cfg_data};

  always_comb begin
    count_next             = count;
    sctl.push              = 1'b0;
    sctl.pop               = 1'b0;
    sctl.clear             = cfg_wr;
    res_next.status        = ST_GRANTED;
    res_next.woken_task    = '0;
    res_next.overflow_flag = 1'b0;
    if (accept) begin
      if (req.req_type == REQ_WAIT) begin
        if (count != '0) begin
          count_next      = count - 1'b1;
          res_next.status = ST_GRANTED;
        end else if (!sstat.full) begin
          sctl.push       = 1'b1;
          res_next.status = ST_BLOCKED;
        end else begin
          res_next.status        = ST_BLOCKED;
          res_next.overflow_flag = 1'b1;
        end
      end else begin
        if (!sstat.empty) begin
          sctl.pop            = 1'b1;
          res_next.status     = ST_WOKE;
          res_next.woken_task = top;
        end else if (count == COUNT_MAX) begin
          res_next.status        = ST_BANKED;
          res_next.overflow_flag = 1'b1;
        end else begin
          count_next      = count + 1'b1;
          res_next.status = ST_BANKED;
        end
      end
    end
    cnt_ext            = {{OUT_CNT_W{1'b0}}, count_next};
    res_next.count_now = cnt_ext[OUT_CNT_W-1:0];
  end

  csl_stack u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sctl),
    .push_data (req.task_id),
    .top       (top),
    .stat      (sstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (cfg_wr) begin
        count <= cfg_ext[COUNT_WIDTH-1:0];
      end else begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= res_next;
    end
  end

  `CSL_ASSERT_NEXT(a_done_follows, clk, rst, accept, done)
  `CSL_ASSERT_NEXT(a_wake_keeps_count, clk, rst,
                   accept && !cfg_wr && req.req_type == REQ_POST && !sstat.empty,
                   $stable(count))
  `CSL_ASSERT_SAME(a_grant_no_ovf, clk, rst,
                   done && result.status == ST_GRANTED, !result.overflow_flag)
  `CSL_ASSERT_SAME(a_woken_zero, clk, rst,
                   done && result.status != ST_WOKE, result.woken_task == '0)

endmodule

FILE: test/tb_counting_semaphore_lifo_waiters.sv
// ----------------------------------------------------------------------------
// tb_counting_semaphore_lifo_waiters
// Self-checking bench for the counting semaphore with LIFO waiters. A driver
// feeds wait/post requests from a queue and a monitor predicts each result
// from its own copy of the count and waiter stack, then checks it against the
// result strobed by done. Phases reload the initial count between bursts.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_lifo_waiters;
  import csl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 165;
  localparam int REPORT_MAX     = 10;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic             busy;
  req_t             req       = '0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             done;
  res_t             result;

  counting_semaphore_lifo_waiters dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [COUNT_WIDTH-1:0] sem_count;
  logic [TASK_W-1:0]      waiters [NUM_TASKS];
  int                     waiter_depth;

  req_t pending_reqs [$];
  res_t due_results  [$];
  int   sender_idle_pct = 0;
  bit   req_taken = 1'b0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   items_taken = 0;
  int   loads_done = 0;
  int   status_seen [4];
  int   overflow_seen = 0;

  function automatic res_t semaphore_step(input req_t r);
    res_t o;
    o = '0;
    if (r.req_type == REQ_WAIT) begin
      if (sem_count != 0) begin
        sem_count--;
        o.status = ST_GRANTED;
      end else if (waiter_depth < NUM_TASKS) begin
        waiters[waiter_depth] = r.task_id;
        waiter_depth++;
        o.status = ST_BLOCKED;
      end else begin
        o.status        = ST_BLOCKED;
        o.overflow_flag = 1'b1;
      end
    end else begin
      if (waiter_depth > 0) begin
        waiter_depth--;
        o.woken_task = waiters[waiter_depth];
        o.status     = ST_WOKE;
      end else begin
        if (&sem_count) o.overflow_flag = 1'b1;
        else sem_count++;
        o.status = ST_BANKED;
      end
    end
    o.count_now = OUT_CNT_W'(sem_count);
    return o;
  endfunction

  function automatic void load_count(input logic [CFG_W-1:0] v);
    sem_count    = COUNT_WIDTH'(v);
    waiter_depth = 0;
  endfunction

  task automatic queue_req(input logic kind, input logic [TASK_W-1:0] id);
    req_t r;
    r.req_type = kind;
    r.task_id  = id;
    pending_reqs.push_back(r);
  endtask

  // runs of waits/posts so the stack fills and empties, mixed with singles
  task automatic queue_random(input int n, input int wait_pct);
    int added;
    int run;
    logic kind;
    added = 0;
    while (added < n) begin
      if ($urandom_range(99) < 15) begin
        kind = ($urandom_range(1) == 0) ? REQ_WAIT : REQ_POST;
        run  = $urandom_range(NUM_TASKS + 3, 3);
        repeat (run) queue_req(kind, TASK_W'($urandom_range(NUM_TASKS - 1)));
        added += run;
      end else begin
        kind = ($urandom_range(99) < wait_pct) ? REQ_WAIT : REQ_POST;
        queue_req(kind, TASK_W'($urandom_range(NUM_TASKS - 1)));
        added++;
      end
    end
  endtask

  task automatic drain;
    while (pending_reqs.size() != 0 || start || due_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_initial_count(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        req   <= pending_reqs.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    res_t exp_res;
    bit   cfg_xfer;
    if (rst) begin
      req_taken    = 1'b0;
      quiet_cycles = 0;
      sem_count    = '0;
      waiter_depth = 0;
      for (int i = 0; i < NUM_TASKS; i++) waiters[i] = '0;
    end else begin
      if (done) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("ERROR: result with nothing outstanding: %p", result);
        end else begin
          exp_res = due_results.pop_front();
          if (result.status !== exp_res.status ||
              result.woken_task !== exp_res.woken_task ||
              result.overflow_flag !== exp_res.overflow_flag ||
              result.count_now !== exp_res.count_now) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("ERROR: status %0d/%0d woken %0d/%0d ovf %0d/%0d count %0d/%0d (exp/got)",
                       exp_res.status, result.status, exp_res.woken_task, result.woken_task,
                       exp_res.overflow_flag, result.overflow_flag,
                       exp_res.count_now, result.count_now);
          end
          status_seen[exp_res.status]++;
          if (exp_res.overflow_flag) overflow_seen++;
        end
      end
      req_taken = start && !busy;
      if (req_taken) begin
        due_results.push_back(semaphore_step(req));
        items_taken++;
      end
      cfg_xfer = cfg_valid && cfg_ready;
      if (cfg_xfer) begin
        load_count(cfg_data);
        loads_done++;
      end
      if (done || req_taken || cfg_xfer) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL counting_semaphore_lifo_waiters");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] load_vals [6];
    int               idle_pcts [6];
    int               wait_pcts [6];
    load_vals = '{16'hFFFF, 16'h0000, 16'h0001, 16'hFFFE, 16'h0000, 16'h0002};
    idle_pcts = '{57, 0, 26, 57, 0, 26};
    wait_pcts = '{30, 60, 50, 20, 75, 45};
    load_vals[4] = CFG_W'($urandom_range(40));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: bank and take, fill stack past full, then wake all in LIFO order
    queue_req(REQ_POST, 3'd0);
    queue_req(REQ_WAIT, 3'd7);
    for (int i = 0; i < NUM_TASKS; i++) queue_req(REQ_WAIT, TASK_W'(i));
    queue_req(REQ_WAIT, 3'd7);
    for (int i = 0; i <= NUM_TASKS; i++) queue_req(REQ_POST, 3'd5);
    queue_req(REQ_WAIT, 3'd7);
    queue_req(REQ_WAIT, 3'd7);
    queue_req(REQ_POST, 3'd0);
    queue_req(REQ_WAIT, 3'd0);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_initial_count(load_vals[p]);
      sender_idle_pct = idle_pcts[p];
      if (&load_vals[p]) begin
        queue_req(REQ_POST, 3'd0);
        queue_req(REQ_WAIT, 3'd1);
        queue_req(REQ_POST, 3'd0);
      end
      queue_random(RAND_PER_PHASE, wait_pcts[p]);
      drain();
    end

    repeat (4) @(posedge clk);
    $display("Covered %0d requests over %0d count loads; granted %0d blocked %0d woke %0d",
             items_taken, loads_done, status_seen[ST_GRANTED], status_seen[ST_BLOCKED],
             status_seen[ST_WOKE]);
    $display("banked %0d, overflow (full stack or saturated count) %0d, mismatches %0d",
             status_seen[ST_BANKED], overflow_seen, mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("PASS counting_semaphore_lifo_waiters");
    end else begin
      $display("FAIL counting_semaphore_lifo_waiters");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/csl_pkg.sv
hdl/csl_cell.sv
hdl/csl_stack.sv
hdl/counting_semaphore_lifo_waiters.sv
test/tb_counting_semaphore_lifo_waiters.sv
